### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, with the check held off during reset.
`define VFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vfd assertion failed");

// Check that an expression never holds outside reset.
`define VFD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("vfd forbidden condition seen");

`endif

### rtl/core/vfd_pkg.sv
// Package: constants, status type and character decode table for the tube serializer
`timescale 1ns / 1ps
package vfd_pkg;

  localparam int TUBE_COUNT_DEF = 8;
  localparam int FRAME_BITS_DEF = 20;

  // Frame layout: segments A..G at positions 0..6, dot at 7, grid at GRID_TOP minus tube
  localparam int SEG_COUNT = 7;
  localparam int DOT_POS   = 7;
  localparam int GRID_TOP  = 15;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCAN  = 1'b1;

  // Shifter status towards the control logic
  typedef struct packed {
    logic busy;  // a frame is still being shifted out
    logic done;  // last bit of the frame is taken this cycle
  } vfd_shift_status_t;

  // Segment pattern A..G, with A in bit 6 and G in bit 0; unknown codes are blank
  function automatic logic [SEG_COUNT-1:0] seg_decode(input logic [7:0] code);
    logic [SEG_COUNT-1:0] seg;
    case (code)
      8'h30: seg = 7'h7E;  // 0
      8'h31: seg = 7'h30;  // 1
      8'h32: seg = 7'h6D;  // 2
      8'h33: seg = 7'h79;  // 3
      8'h34: seg = 7'h33;  // 4
      8'h35: seg = 7'h5B;  // 5
      8'h36: seg = 7'h5F;  // 6
      8'h37: seg = 7'h70;  // 7
      8'h38: seg = 7'h7F;  // 8
      8'h39: seg = 7'h7B;  // 9
      8'h41: seg = 7'h77;  // A
      8'h42: seg = 7'h1F;  // B
      8'h63: seg = 7'h4E;  // c
      8'h43: seg = 7'h4E;  // C
      8'h44: seg = 7'h3D;  // D
      8'h45: seg = 7'h4F;  // E
      8'h46: seg = 7'h47;  // F
      8'h47: seg = 7'h5E;  // G
      8'h48: seg = 7'h37;  // H
      8'h68: seg = 7'h17;  // h
      8'h49: seg = 7'h06;  // I
      8'h4A: seg = 7'h38;  // J
      8'h4C: seg = 7'h0E;  // L
      8'h4E: seg = 7'h76;  // N
      8'h6E: seg = 7'h15;  // n
      8'h6F: seg = 7'h1D;  // o
      8'h50: seg = 7'h67;  // P
      8'h72: seg = 7'h05;  // r
      8'h74: seg = 7'h0F;  // t
      8'h55: seg = 7'h3E;  // U
      8'h75: seg = 7'h1C;  // u
      8'h79: seg = 7'h3B;  // y
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

### rtl/core/vfd_if.sv
// Channel interfaces: command input and serial frame output
`timescale 1ns / 1ps

interface vfd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [2:0] tube_index;
  logic [7:0] char_code;
  logic       dot_on;

  modport source (output valid, op, tube_index, char_code, dot_on, input ready);
  modport sink   (input valid, op, tube_index, char_code, dot_on, output ready);
endinterface

interface vfd_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch;

  modport source (output valid, serial_bit, latch, input ready);
  modport sink   (input valid, serial_bit, latch, output ready);
endinterface

### rtl/core/vfd_shifter.sv
// Frame shift register: sends a loaded frame one bit per transaction, MSB first
`timescale 1ns / 1ps
module vfd_shifter #(
  parameter int FRAME_BITS = vfd_pkg::FRAME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [FRAME_BITS-1:0]     frame_in,
  output vfd_pkg::vfd_shift_status_t status,
  vfd_out_if.source                 out_if
);

  localparam int CNT_W = $clog2(FRAME_BITS + 1);

  logic [FRAME_BITS-1:0] frame_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  take;

  assign out_if.valid      = (cnt_r != '0);
  assign out_if.serial_bit = frame_r[FRAME_BITS-1];
  assign out_if.latch      = (cnt_r == CNT_W'(1));
  assign take              = out_if.valid && out_if.ready;

  assign status.busy = out_if.valid;
  assign status.done = take && out_if.latch;

  // Count remaining bits; a new load wins over the final take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= CNT_W'(FRAME_BITS);
    end else if (take) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame_in;
    end else if (take) begin
      frame_r <= {frame_r[FRAME_BITS-2:0], 1'b0};
    end
  end

endmodule

### rtl/core/vfd_tube_frame_serializer_top.sv
// Top level: tube store, scan pointer, frame build and serial frame output
//
//  channel | dir | payload                              | transaction
//  --------+-----+--------------------------------------+----------------------------
//  in_if   | in  | op, tube_index, char_code, dot_on    | one write or one scan
//  out_if  | out | serial_bit, latch                    | one frame bit, MSB first
//
// A write gives no output. A scan gives FRAME_BITS output
// transactions, one per cycle at best, set by the single-bit frame shift register.
// in_if.ready is low while a frame is being shifted; it rises again in the cycle
// whose output transaction carries latch, so a back-to-back scan costs no gap.
// rst_n (synchronous) blanks all tubes, clears all dots and points the scan at tube 0.
// An output stall simply holds the current bit and the input stays blocked.
`timescale 1ns / 1ps
module vfd_tube_frame_serializer_top #(
  parameter int TUBE_COUNT = vfd_pkg::TUBE_COUNT_DEF,
  parameter int FRAME_BITS = vfd_pkg::FRAME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vfd_in_if.sink    in_if,
  vfd_out_if.source out_if
);

  localparam int PTR_W  = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1;
  localparam int FPOS_W = $clog2(FRAME_BITS);

  // Per-tube character and dot store
  logic [7:0]            char_r [TUBE_COUNT];
  logic [TUBE_COUNT-1:0] dot_r;
  logic [PTR_W-1:0]      ptr_r;
  logic [PTR_W-1:0]      ptr_nxt;

  vfd_pkg::vfd_shift_status_t    shift_st;
  logic                          in_ready;
  logic                          in_take;
  logic                          scan_take;
  logic                          wr_take;
  logic [PTR_W-1:0]              wr_idx;
  logic [vfd_pkg::SEG_COUNT-1:0] seg;
  logic [FPOS_W-1:0]             grid_pos;
  logic [FRAME_BITS-1:0]         frame_load;

  // Accept while idle, or as the last bit of the current frame goes out
  assign in_ready    = !shift_st.busy || shift_st.done;
  assign in_if.ready = in_ready;
  assign in_take     = in_if.valid && in_ready;
  assign scan_take   = in_take && (in_if.op == vfd_pkg::OP_SCAN);
  // Drop writes to tubes that are not fitted
  assign wr_take     = in_take && (in_if.op == vfd_pkg::OP_WRITE) &&
                       (int'(in_if.tube_index) < TUBE_COUNT);
  assign wr_idx      = in_if.tube_index[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TUBE_COUNT; i++) begin
        char_r[i] <= '0;
      end
      dot_r <= '0;
    end else if (wr_take) begin
      char_r[wr_idx] <= in_if.char_code;
      dot_r[wr_idx]  <= in_if.dot_on;
    end
  end

  // Advance the scan pointer after each scan, wrapping after the last tube
  assign ptr_nxt = (ptr_r == PTR_W'(TUBE_COUNT - 1)) ? '0 : ptr_r + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (scan_take) begin
      ptr_r <= ptr_nxt;
    end
  end

  // Build the frame for the tube under the pointer: segments reversed so that
  // A lands at position 0, then dot, then the grid bit for this tube
  assign seg      = vfd_pkg::seg_decode(char_r[ptr_r]);
  assign grid_pos = FPOS_W'(vfd_pkg::GRID_TOP) - FPOS_W'(ptr_r);

  always_comb begin
    frame_load = '0;
    for (int k = 0; k < vfd_pkg::SEG_COUNT; k++) begin
      frame_load[k] = seg[vfd_pkg::SEG_COUNT-1-k];
    end
    frame_load[vfd_pkg::DOT_POS] = dot_r[ptr_r];
    frame_load[grid_pos]         = 1'b1;
  end

  vfd_shifter #(
    .FRAME_BITS (FRAME_BITS)
  ) u_shifter (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (scan_take),
    .frame_in (frame_load),
    .status   (shift_st),
    .out_if   (out_if)
  );

endmodule

### rtl/core/vfd_checker.sv
// Port-level checker for the tube frame serializer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vfd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_op,
  input logic out_valid,
  input logic out_ready,
  input logic out_serial_bit,
  input logic out_latch
);

  logic in_scan;
  logic out_last;

  assign in_scan  = in_valid && in_ready && (in_op == vfd_pkg::OP_SCAN);
  assign out_last = out_valid && out_ready && out_latch;

  // No new transaction is taken in the middle of a frame
  `VFD_ASSERT_NEVER(a_no_take_mid_frame, clk, rst_n, out_valid && !out_last && in_ready)

  // A scan starts a frame on the next cycle, and its first bit is not the last
  `VFD_ASSERT(a_scan_starts_frame, clk, rst_n, in_scan |=> (out_valid && !out_latch))

  // Once the latch bit is taken, output goes quiet unless a scan came in with it
  `VFD_ASSERT(a_frame_ends, clk, rst_n, (out_last && !in_scan) |=> !out_valid)

  // A write never starts output
  `VFD_ASSERT(a_write_silent, clk, rst_n, (!out_valid && !in_scan) |=> !out_valid)

  // A stalled bit holds
  `VFD_ASSERT(a_stall_holds, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_serial_bit) && $stable(out_latch)))

endmodule

bind vfd_tube_frame_serializer_top vfd_checker u_vfd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .in_op          (in_if.op),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_serial_bit (out_if.serial_bit),
  .out_latch      (out_if.latch)
);

### bench/vfd_tube_frame_serializer_top_tb.sv
// Testbench for the tube frame serializer: directed table, random traffic, bit-level checks
`timescale 1ns / 1ps
module vfd_tube_frame_serializer_top_tb;

  localparam int TUBE_COUNT  = vfd_pkg::TUBE_COUNT_DEF;
  localparam int FRAME_BITS  = vfd_pkg::FRAME_BITS_DEF;
  localparam int RANDOM_CMDS = 310;
  // one long receiver hold to fill the block and back-pressure the input
  localparam int LONG_HOLD   = 250;
  localparam int HOLD_AT     = 120;
  // quiet cycles tolerated: long hold plus a burst on each side, with margin
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 3 * FRAME_BITS;

  typedef struct packed {
    logic       op;
    logic [2:0] tube;
    logic [7:0] code;
    logic       dot;
  } tube_cmd_t;

  typedef struct packed {
    logic serial_bit;
    logic latch;
  } frame_bit_t;

  // directed row: a command and, where obvious, the frame it must produce
  typedef struct packed {
    tube_cmd_t             cmd;
    logic                  pinned;
    logic [FRAME_BITS-1:0] frame;
  } directed_row_t;

  logic clk;
  logic rst_n;

  vfd_in_if  in_ch ();
  vfd_out_if out_ch ();

  vfd_tube_frame_serializer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Predictor state: a private copy of the tube store and the scan pointer
  logic [7:0] tube_chars     [TUBE_COUNT];
  logic       tube_dot_flags [TUBE_COUNT];
  int         scan_ptr;

  // Frame bits still owed by the block, oldest first
  frame_bit_t frame_bits_due [$];

  int  mismatch_count;
  int  quiet_cycles;
  int  idle_odds;    // 1-in-N chance of an idle burst per decision; 0 disables idling
  bit  drain_hold;   // raised by the sender, served by the receiver
  string glyph_set = "0123456789ABcCDEFGHhIJLNnoPrtUuy";

  // Directed stimulus. Pinned frames are the ones readable straight off the layout:
  // blank tube after reset, a full eight with dot, an unknown code with dot on tube 7.
  directed_row_t directed_rows [20] = '{
    '{'{vfd_pkg::OP_SCAN,  3'd0, 8'h00, 1'b0}, 1'b1, 20'h08000},  // blank tube 0 after reset
    '{'{vfd_pkg::OP_WRITE, 3'd1, 8'h38, 1'b1}, 1'b0, 20'h00000},  // '8' with dot
    '{'{vfd_pkg::OP_SCAN,  3'd7, 8'hFF, 1'b1}, 1'b1, 20'h040FF},  // scan ignores its fields
    '{'{vfd_pkg::OP_WRITE, 3'd7, 8'hFF, 1'b1}, 1'b0, 20'h00000},  // unknown code, top index
    '{'{vfd_pkg::OP_WRITE, 3'd2, 8'h41, 1'b0}, 1'b0, 20'h00000},  // 'A'
    '{'{vfd_pkg::OP_WRITE, 3'd3, 8'h72, 1'b1}, 1'b0, 20'h00000},  // 'r'
    '{'{vfd_pkg::OP_WRITE, 3'd4, 8'h79, 1'b0}, 1'b0, 20'h00000},  // 'y'
    '{'{vfd_pkg::OP_WRITE, 3'd5, 8'h31, 1'b1}, 1'b0, 20'h00000},  // '1'
    '{'{vfd_pkg::OP_WRITE, 3'd6, 8'h63, 1'b0}, 1'b0, 20'h00000},  // lower-case 'c'
    '{'{vfd_pkg::OP_WRITE, 3'd0, 8'h30, 1'b1}, 1'b0, 20'h00000},  // '0'
    '{'{vfd_pkg::OP_SCAN,  3'd0, 8'h00, 1'b0}, 1'b0, 20'h00000},
    '{'{vfd_pkg::OP_SCAN,  3'd5, 8'h55, 1'b1}, 1'b0, 20'h00000},
    '{'{vfd_pkg::OP_SCAN,  3'd2, 8'hAA, 1'b0}, 1'b0, 20'h00000},
    '{'{vfd_pkg::OP_SCAN,  3'd7, 8'h80, 1'b1}, 1'b0, 20'h00000},
    '{'{vfd_pkg::OP_SCAN,  3'd1, 8'h7F, 1'b0}, 1'b0, 20'h00000},
    '{'{vfd_pkg::OP_SCAN,  3'd0, 8'h00, 1'b0}, 1'b1, 20'h00180},  // tube 7: dot and grid only
    '{'{vfd_pkg::OP_SCAN,  3'd3, 8'h01, 1'b1}, 1'b0, 20'h00000},  // pointer wraps to tube 0
    '{'{vfd_pkg::OP_WRITE, 3'd0, 8'h00, 1'b0}, 1'b0, 20'h00000},  // back to blank
    '{'{vfd_pkg::OP_WRITE, 3'd6, 8'h7F, 1'b1}, 1'b0, 20'h00000},
    '{'{vfd_pkg::OP_SCAN,  3'd4, 8'hFE, 1'b0}, 1'b0, 20'h00000}
  };

  // Segment pattern for a character, A in bit 6 down to G in bit 0; blank when unknown
  function automatic logic [6:0] glyph_segments(input logic [7:0] code);
    case (code)
      "0": return 7'b1111110;
      "1": return 7'b0110000;
      "2": return 7'b1101101;
      "3": return 7'b1111001;
      "4": return 7'b0110011;
      "5": return 7'b1011011;
      "6": return 7'b1011111;
      "7": return 7'b1110000;
      "8": return 7'b1111111;
      "9": return 7'b1111011;
      "A": return 7'b1110111;
      "B": return 7'b0011111;
      "c", "C": return 7'b1001110;
      "D": return 7'b0111101;
      "E": return 7'b1001111;
      "F": return 7'b1000111;
      "G": return 7'b1011110;
      "H": return 7'b0110111;
      "h": return 7'b0010111;
      "I": return 7'b0000110;
      "J": return 7'b0111000;
      "L": return 7'b0001110;
      "N": return 7'b1110110;
      "n": return 7'b0010101;
      "o": return 7'b0011101;
      "P": return 7'b1100111;
      "r": return 7'b0000101;
      "t": return 7'b0001111;
      "U": return 7'b0111110;
      "u": return 7'b0011100;
      "y": return 7'b0111011;
      default: return 7'b0000000;
    endcase
  endfunction

  // Build the frame for the tube under the pointer, then advance the pointer
  function automatic logic [FRAME_BITS-1:0] next_scan_frame();
    logic [6:0]            seg;
    logic [FRAME_BITS-1:0] frame;
    int                    tube;
    int                    k;
    tube  = (scan_ptr < TUBE_COUNT) ? scan_ptr : 0;
    seg   = glyph_segments(tube_chars[tube]);
    frame = '0;
    // segment A lands at position 0, G at position 6
    for (k = 0; k < 7; k++) frame[k] = seg[6 - k];
    frame[7]         = tube_dot_flags[tube];
    frame[15 - tube] = 1'b1;
    scan_ptr = (tube + 1 >= TUBE_COUNT) ? 0 : tube + 1;
    return frame;
  endfunction

  // Update the predictor for one accepted command and queue any frame bits it owes
  task automatic predict_command(input tube_cmd_t cmd, input logic pinned,
                                 input logic [FRAME_BITS-1:0] pinned_frame);
    logic [FRAME_BITS-1:0] frame;
    int                    k;
    if (cmd.op == vfd_pkg::OP_WRITE) begin
      // indexes past the last tube are dropped
      if (cmd.tube < TUBE_COUNT) begin
        tube_chars[cmd.tube]     = cmd.code;
        tube_dot_flags[cmd.tube] = cmd.dot;
      end
    end else begin
      frame = next_scan_frame();
      if (pinned) frame = pinned_frame;
      // highest position first, latch on position 0
      for (k = FRAME_BITS - 1; k >= 0; k--) begin
        frame_bits_due.push_back('{serial_bit: frame[k], latch: (k == 0)});
      end
    end
  endtask

  // Offer one command, optionally after an idle burst, and hold it until the block takes it
  task automatic send_command(input tube_cmd_t cmd, input logic pinned,
                              input logic [FRAME_BITS-1:0] pinned_frame);
    int gap;
    gap = 0;
    if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) gap = $urandom_range(18, 1);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= cmd.op;
    in_ch.tube_index <= cmd.tube;
    in_ch.char_code  <= cmd.code;
    in_ch.dot_on     <= cmd.dot;
    do @(posedge clk); while (!in_ch.ready);
    predict_command(cmd, pinned, pinned_frame);
  endtask

  // Random command: scans and writes in equal share, mostly known glyphs on writes
  function automatic tube_cmd_t random_command();
    tube_cmd_t cmd;
    cmd.op   = $urandom_range(1, 0) ? vfd_pkg::OP_SCAN : vfd_pkg::OP_WRITE;
    cmd.tube = 3'($urandom_range(7, 0));
    if ($urandom_range(2, 0) == 0) cmd.code = 8'($urandom_range(255, 0));
    else cmd.code = glyph_set.getc($urandom_range(glyph_set.len() - 1, 0));
    cmd.dot  = 1'($urandom_range(1, 0));
    return cmd;
  endfunction

  // Clock: 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Reset at the start, once
  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    int k;
    for (k = 0; k < TUBE_COUNT; k++) begin
      tube_chars[k]     = 8'h00;
      tube_dot_flags[k] = 1'b0;
    end
    scan_ptr       = 0;
    mismatch_count = 0;
    drain_hold     = 1'b0;
    idle_odds      = 5;
  end

  // Sender: directed table, then random traffic in phases, ending with no idling
  initial begin
    int i;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= vfd_pkg::OP_WRITE;
    in_ch.tube_index <= '0;
    in_ch.char_code  <= '0;
    in_ch.dot_on     <= 1'b0;
    do @(posedge clk); while (!rst_n);

    for (i = 0; i < $size(directed_rows); i++) begin
      send_command(directed_rows[i].cmd, directed_rows[i].pinned, directed_rows[i].frame);
    end

    for (i = 0; i < RANDOM_CMDS; i++) begin
      // heavy idling, then light, then a stretch with none, then heavy again, then none
      if (i < 100) idle_odds = 3;
      else if (i < 170) idle_odds = 12;
      else if (i < 210) idle_odds = 0;
      else if (i < 250) idle_odds = 4;
      else idle_odds = 0;
      if (i == HOLD_AT) drain_hold = 1'b1;
      send_command(random_command(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    // drain, then allow time for any stray bits to show up
    while (frame_bits_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("vfd_tube_frame_serializer_top: match");
    end else begin
      $display("vfd_tube_frame_serializer_top: mismatch");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold to back the block up
  initial begin
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (drain_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        drain_hold = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(18, 1)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Compare every output transaction with the oldest owed frame bit
  always @(posedge clk) begin
    frame_bit_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frame_bits_due.size() == 0) begin
        $error("unexpected output transaction: serial_bit %0b latch %0b",
               out_ch.serial_bit, out_ch.latch);
        mismatch_count++;
      end else begin
        due = frame_bits_due.pop_front();
        if (out_ch.serial_bit !== due.serial_bit) begin
          $error("serial_bit: expected %0b, got %0b", due.serial_bit, out_ch.serial_bit);
          mismatch_count++;
        end
        if (out_ch.latch !== due.latch) begin
          $error("latch: expected %0b, got %0b", due.latch, out_ch.latch);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("vfd_tube_frame_serializer_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/vfd_pkg.sv
rtl/core/vfd_if.sv
rtl/core/vfd_shifter.sv
rtl/core/vfd_tube_frame_serializer_top.sv
rtl/core/vfd_checker.sv
bench/vfd_tube_frame_serializer_top_tb.sv
